// File: src/gshare_branch_predictor_assert.svh
// Assertion macros for the gshare branch predictor checkers.
`ifndef GSHARE_BRANCH_PREDICTOR_ASSERT_SVH
`define GSHARE_BRANCH_PREDICTOR_ASSERT_SVH

// Concurrent assertion with an explicit clock and active-low reset.
`define GBP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define GBP_ASSERT(label, prop, msg) \
  `GBP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: src/gbp_pkg.sv
// Package with the constants, types and helper functions of the gshare predictor.
package gbp_pkg;

  // Table and history sizes.
  localparam int LogTableEntries = 12;
  localparam int HistoryBits     = 64;
  localparam int TableDepth      = 1 << LogTableEntries;
  localparam int TblIdxW         = LogTableEntries;

  // Field widths of the channels.
  localparam int PcW         = 64;
  localparam int IdxFieldW   = 12;
  localparam int CountW      = 32;
  localparam int ShiftW      = 6;
  localparam int CtrW        = 2;
  localparam int FoldW       = 16;

  // Configuration port.
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic RegPcShift = 1'b0;

  // Operation code of an input item.
  typedef enum logic {
    FuncPredict = 1'b0,
    FuncUpdate  = 1'b1
  } func_e;

  // Request from the pipeline to the counter table.
  typedef struct packed {
    logic               rd_en;
    logic [TblIdxW-1:0] rd_addr;
    logic               wr_en;
    logic [TblIdxW-1:0] wr_addr;
    logic [CtrW-1:0]    wr_data;
  } tbl_req_t;

  // Fold a 64-bit history down to 16 bits by two XOR halvings.
  function automatic logic [FoldW-1:0] fold_history(input logic [63:0] h);
    logic [31:0] f;
    f = h[63:32] ^ h[31:0];
    return f[31:16] ^ f[15:0];
  endfunction

  // Move a 2-bit counter one step toward the outcome, saturating at both ends.
  function automatic logic [CtrW-1:0] ctr_step(input logic [CtrW-1:0] c, input logic tk);
    logic [CtrW-1:0] r;
    r = c;
    if (tk) begin
      if (c != '1) r = c + CtrW'(1);
    end else begin
      if (c != '0) r = c - CtrW'(1);
    end
    return r;
  endfunction

  // Saturating increment of an event count.
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (&v) ? v : v + CountW'(1);
  endfunction

endpackage

// File: src/gbp_in_if.sv
// Input channel interface of the gshare predictor: lookups and updates.
interface gbp_in_if;
  logic                            valid;
  logic                            ready;
  gbp_pkg::func_e                  func;
  logic [gbp_pkg::PcW-1:0]         pc;
  logic [gbp_pkg::IdxFieldW-1:0]   table_index;
  logic                            predicted_taken;
  logic                            taken;

  modport source (output valid, func, pc, table_index, predicted_taken, taken,
                  input ready);
  modport sink (input valid, func, pc, table_index, predicted_taken, taken,
                output ready);
endinterface

// File: src/gbp_out_if.sv
// Result channel interface of the gshare predictor.
interface gbp_out_if;
  logic                            valid;
  logic                            ready;
  logic                            predict_taken;
  logic [gbp_pkg::IdxFieldW-1:0]   index_out;
  logic [gbp_pkg::CountW-1:0]      branch_total;
  logic [gbp_pkg::CountW-1:0]      mispredict_total;

  modport source (output valid, predict_taken, index_out, branch_total, mispredict_total,
                  input ready);
  modport sink (input valid, predict_taken, index_out, branch_total, mispredict_total,
                output ready);
endinterface

// File: src/gbp_hash.sv
// Index hash: folded global history XORed with the shifted branch address.
module gbp_hash (
  input  logic [gbp_pkg::PcW-1:0]         pc_i,
  input  logic [gbp_pkg::ShiftW-1:0]      addr_shift_i,
  input  logic [gbp_pkg::HistoryBits-1:0] hist_i,
  output logic [gbp_pkg::TblIdxW-1:0]     idx_o
);

  logic [gbp_pkg::FoldW-1:0] fold;

  // Fold the history and combine it with the low bits of the shifted address.
  assign fold  = gbp_pkg::fold_history(64'(hist_i));
  assign idx_o = gbp_pkg::TblIdxW'(pc_i << addr_shift_i) ^ gbp_pkg::TblIdxW'(fold);

endmodule

// File: src/gbp_table.sv
// Counter table: synchronous memory of 2-bit counters with a clearing sweep after reset.
module gbp_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gbp_pkg::tbl_req_t         req_i,
  output logic [gbp_pkg::CtrW-1:0]  rd_data_o,
  output logic                      ready_o
);

  logic [gbp_pkg::CtrW-1:0]    counter_mem_q [gbp_pkg::TableDepth];
  logic [gbp_pkg::CtrW-1:0]    rd_data_q;
  logic [gbp_pkg::TblIdxW:0]   clr_cnt_q;
  logic [gbp_pkg::TblIdxW:0]   clr_cnt_d;
  logic                        clearing;
  logic                        wr_en;
  logic [gbp_pkg::TblIdxW-1:0] wr_addr;
  logic [gbp_pkg::CtrW-1:0]    wr_data;

  // The sweep is done once the counter has passed the last entry.
  assign clearing = !clr_cnt_q[gbp_pkg::TblIdxW];
  assign ready_o  = !clearing;
  assign clr_cnt_d = clearing ? clr_cnt_q + (gbp_pkg::TblIdxW + 1)'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // The sweep owns the write port until every counter has been zeroed.
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q[gbp_pkg::TblIdxW-1:0];
      wr_data = '0;
    end else begin
      wr_en   = req_i.wr_en;
      wr_addr = req_i.wr_addr;
      wr_data = req_i.wr_data;
    end
  end

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      counter_mem_q[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= counter_mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/gshare_branch_predictor.sv
// Top level of the gshare branch predictor.
//
// Input channel in_i carries predict lookups (func = predict, pc) and
// updates (func = update, table_index, predicted_taken, taken). Each
// accepted item gives exactly one transfer on out_o: the prediction (0 for
// updates), the table index, and the branch and mispredict totals after it.
// The shift applied to the branch address is set over the APB port (register 0,
// byte address 0) by the user only while the block is idle; the block does not enforce it.
//
// Each item passes through the in-flight stage: the counter memory is read
// at the edge that accepts the item and written back when the item moves on
// into the output register, and the next item is accepted only after that
// write-back, so a new item is never taken before the last one is through.
// The result is registered. If the receiver stalls, the result waits in the
// output register and one further item can be read and held; input ready then stays low.
//
// After reset the history and totals are zero and a sweep clears the 4096
// counters, one per cycle; input ready stays low until the sweep is done.
module gshare_branch_predictor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gbp_in_if.sink                      in_i,
  gbp_out_if.source                   out_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [gbp_pkg::PaddrW-1:0]  paddr_i,
  input  logic [gbp_pkg::PdataW-1:0]  pwdata_i,
  output logic [gbp_pkg::PdataW-1:0]  prdata_o,
  output logic                        pready_o
);

  // Configuration and architectural state.
  logic [gbp_pkg::ShiftW-1:0]      addr_shift_q;
  logic [gbp_pkg::HistoryBits-1:0] hist_q, hist_d;
  logic [gbp_pkg::CountW-1:0]      branch_cnt_q, branch_cnt_d;
  logic [gbp_pkg::CountW-1:0]      mispred_cnt_q, mispred_cnt_d;

  // Item in flight while its counter is read.
  logic                        s1_valid_q;
  gbp_pkg::func_e              s1_func_q;
  logic [gbp_pkg::TblIdxW-1:0] s1_idx_q;
  logic                        s1_pred_q;
  logic                        s1_taken_q;

  // Output register.
  logic                          out_valid_q;
  logic                          out_ptaken_q;
  logic [gbp_pkg::IdxFieldW-1:0] out_idx_q;
  logic [gbp_pkg::CountW-1:0]    out_branch_q;
  logic [gbp_pkg::CountW-1:0]    out_mispred_q;

  logic                        in_fire;
  logic                        s1_fire;
  logic                        cfg_write;
  logic                        tbl_ready;
  logic [gbp_pkg::TblIdxW-1:0] hash_idx;
  logic [gbp_pkg::TblIdxW-1:0] in_idx;
  logic [gbp_pkg::CtrW-1:0]    ctr_rd;
  gbp_pkg::tbl_req_t           tbl_req;

  // APB register access; writes complete in the access phase.
  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i && (paddr_i[2] == gbp_pkg::RegPcShift);
  assign prdata_o  = (paddr_i[2] == gbp_pkg::RegPcShift) ?
                     gbp_pkg::PdataW'(addr_shift_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_shift_q <= '0;
    end else if (cfg_write) begin
      addr_shift_q <= pwdata_i[gbp_pkg::ShiftW-1:0];
    end
  end

  // Index of the incoming item: hashed for lookups, given for updates.
  gbp_hash u_hash (
    .pc_i         (in_i.pc),
    .addr_shift_i (addr_shift_q),
    .hist_i       (hist_q),
    .idx_o        (hash_idx)
  );

  assign in_idx = (in_i.func == gbp_pkg::FuncUpdate) ?
                  gbp_pkg::TblIdxW'(in_i.table_index) : hash_idx;

  // Handshakes: one item in flight, the output register frees the in-flight stage.
  assign in_i.ready = tbl_ready && !s1_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);

  // Counter memory requests: read on acceptance, write back on completion.
  always_comb begin
    tbl_req.rd_en   = in_fire;
    tbl_req.rd_addr = in_idx;
    tbl_req.wr_en   = s1_fire && (s1_func_q == gbp_pkg::FuncUpdate);
    tbl_req.wr_addr = s1_idx_q;
    tbl_req.wr_data = gbp_pkg::ctr_step(ctr_rd, s1_taken_q);
  end

  gbp_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_data_o (ctr_rd),
    .ready_o   (tbl_ready)
  );

  // In-flight stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q  <= in_i.func;
      s1_idx_q   <= in_idx;
      s1_pred_q  <= in_i.predicted_taken;
      s1_taken_q <= in_i.taken;
    end
  end

  // History and totals advance when an update completes.
  always_comb begin
    hist_d        = hist_q;
    branch_cnt_d  = branch_cnt_q;
    mispred_cnt_d = mispred_cnt_q;
    if (s1_fire && (s1_func_q == gbp_pkg::FuncUpdate)) begin
      hist_d       = gbp_pkg::HistoryBits'({hist_q, s1_taken_q});
      branch_cnt_d = gbp_pkg::sat_inc(branch_cnt_q);
      if (s1_pred_q != s1_taken_q) begin
        mispred_cnt_d = gbp_pkg::sat_inc(mispred_cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q        <= '0;
      branch_cnt_q  <= '0;
      mispred_cnt_q <= '0;
    end else begin
      hist_q        <= hist_d;
      branch_cnt_q  <= branch_cnt_d;
      mispred_cnt_q <= mispred_cnt_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_ptaken_q  <= (s1_func_q == gbp_pkg::FuncPredict) && ctr_rd[gbp_pkg::CtrW-1];
      out_idx_q     <= gbp_pkg::IdxFieldW'(s1_idx_q);
      out_branch_q  <= branch_cnt_d;
      out_mispred_q <= mispred_cnt_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.predict_taken    = out_ptaken_q;
  assign out_o.index_out        = out_idx_q;
  assign out_o.branch_total     = out_branch_q;
  assign out_o.mispredict_total = out_mispred_q;

endmodule

// File: src/gbp_port_checker.sv
// Port-level checker for the gshare predictor, bound to the top level.
`include "gshare_branch_predictor_assert.svh"

module gbp_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_ptaken_i,
  input logic [gbp_pkg::IdxFieldW-1:0] out_idx_i,
  input logic [gbp_pkg::CountW-1:0]    out_branch_i,
  input logic [gbp_pkg::CountW-1:0]    out_mispred_i
);

  // A stalled result stays offered.
  `GBP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")

  // A stalled result keeps its payload.
  `GBP_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_ptaken_i) && $stable(out_idx_i) && $stable(out_branch_i) && $stable(out_mispred_i), "result changed while stalled")

  // Mispredicts can never outnumber branches.
  `GBP_ASSERT(a_count_order, out_valid_i |-> out_mispred_i <= out_branch_i, "mispredict total above branch total")

  // Only one item is in flight: ready drops after every accepted item.
  `GBP_ASSERT(a_one_in_flight, in_valid_i && in_ready_i |=> !in_ready_i, "second item taken while one in flight")

endmodule

bind gshare_branch_predictor gbp_port_checker u_gbp_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_ptaken_i  (out_o.predict_taken),
  .out_idx_i     (out_o.index_out),
  .out_branch_i  (out_o.branch_total),
  .out_mispred_i (out_o.mispredict_total)
);
